[rtl/nonpreemptive_priority_scheduler_unit_macros.svh]
// Assertion macros for the priority scheduler unit.
// Used by the top level only; needs clk_i and rst_ni in scope.
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/nps_pkg.sv]
// Shared types and field widths of the priority scheduler unit.
// No dependencies.
package nps_pkg;

  localparam int unsigned BurstW   = 16;
  localparam int unsigned ArrivalW = 16;
  localparam int unsigned PrioW    = 8;
  localparam int unsigned JobIdxW  = 4;
  localparam int unsigned OutTimeW = 21;

  // One stored job word.
  typedef struct packed {
    logic [BurstW-1:0]   burst;
    logic [ArrivalW-1:0] arrival;
    logic [PrioW-1:0]    prio;
  } job_t;

endpackage

[rtl/nonpreemptive_priority_scheduler_unit.sv]
// Non-preemptive priority scheduler: loads jobs, schedules the set, reports times.
// Depends on nps_pkg and nonpreemptive_priority_scheduler_unit_macros.svh.
// Load: one job word per cycle, busy_o stays low. After the last job, N rounds
//   of one scan over the job memory (one read port), then N result words,
//   one per cycle.
// Reset clears job count, served flags and tick; job memories are not cleared.
`include "nonpreemptive_priority_scheduler_unit_macros.svh"

module nonpreemptive_priority_scheduler_unit
  import nps_pkg::*;
#(
  parameter int unsigned MAX_PROCS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [BurstW-1:0]   burst_time_i,
  input  logic [ArrivalW-1:0] arrival_time_i,
  input  logic [PrioW-1:0]    job_priority_i,
  input  logic                last_job_i,
  output logic                result_valid_o,
  output logic [JobIdxW-1:0]  job_index_o,
  output logic [OutTimeW-1:0] waiting_time_o,
  output logic [OutTimeW-1:0] turnaround_time_o,
  output logic                last_result_o
);

  localparam int unsigned CntW  = $clog2(MAX_PROCS + 1);
  localparam int unsigned IdxW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned TickW = BurstW + $clog2(MAX_PROCS + 1);
  localparam int unsigned WideW = (TickW > OutTimeW) ? TickW : OutTimeW;
  localparam int unsigned XIdxW = (IdxW > JobIdxW) ? IdxW : JobIdxW;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StCommit,
    StEmit
  } state_e;

  state_e state_q;

  // Set bookkeeping
  logic [CntW-1:0]      cnt_q;
  logic [CntW-1:0]      done_q;
  logic [TickW-1:0]     tick_q;
  logic [MAX_PROCS-1:0] served_q;

  // Memory read sequencing
  logic [CntW-1:0] scan_q;
  logic            rv_q;
  logic [IdxW-1:0] ridx_q;

  // Best arrived candidate
  logic              fnd_q;
  logic [PrioW-1:0]  bpri_q;
  logic [IdxW-1:0]   bidx_q;
  logic [BurstW-1:0] bburst_q;

  // Earliest pending candidate
  logic                eany_q;
  logic [ArrivalW-1:0] earr_q;
  logic [PrioW-1:0]    epri_q;
  logic [IdxW-1:0]     eidx_q;
  logic [BurstW-1:0]   eburst_q;

  // Result registers
  logic                res_valid_q;
  logic [JobIdxW-1:0]  res_idx_q;
  logic [OutTimeW-1:0] res_wait_q;
  logic [OutTimeW-1:0] res_turn_q;
  logic                res_last_q;

  // Memories
  job_t             job_mem [MAX_PROCS];
  logic [TickW-1:0] start_mem [MAX_PROCS];
  job_t             rd_q;
  logic [TickW-1:0] st_rd_q;

  logic             load_acc;
  logic             load_we;
  logic             issue;
  logic [IdxW-1:0]  rd_addr;
  logic             rd_is_last;
  logic             cand_ok;
  logic             arrived;
  logic             take_best;
  logic             take_early;
  logic [IdxW-1:0]  pick_idx;
  logic [TickW-1:0] pick_start;
  logic [TickW-1:0] pick_next;
  logic             commit_we;
  logic [WideW-1:0] wait_full;
  logic [WideW-1:0] turn_full;
  logic [XIdxW-1:0] ridx_ext;

  assign busy_o   = (state_q != StIdle);
  assign load_acc = start_i && !busy_o;
  assign load_we  = load_acc && (cnt_q < CntW'(MAX_PROCS));

  assign issue      = (scan_q < cnt_q);
  assign rd_addr    = scan_q[IdxW-1:0];
  assign rd_is_last = (CntW'(ridx_q) == (cnt_q - CntW'(1)));

  // Compare the word read back against both candidate trackers
  assign cand_ok    = rv_q && !served_q[ridx_q];
  assign arrived    = (TickW'(rd_q.arrival) <= tick_q);
  assign take_best  = cand_ok && arrived && (!fnd_q || (rd_q.prio < bpri_q));
  assign take_early = cand_ok && (!eany_q || (rd_q.arrival < earr_q) ||
                      ((rd_q.arrival == earr_q) && (rd_q.prio < epri_q)));

  // Pick the winner; an idle CPU jumps to the earliest pending arrival
  always_comb begin
    if (fnd_q) begin
      pick_idx   = bidx_q;
      pick_start = tick_q;
      pick_next  = tick_q + TickW'(bburst_q);
    end else begin
      pick_idx   = eidx_q;
      pick_start = TickW'(earr_q);
      pick_next  = TickW'(earr_q) + TickW'(eburst_q);
    end
  end

  assign commit_we = (state_q == StCommit);

  // Result arithmetic
  assign wait_full = WideW'(st_rd_q) - WideW'(rd_q.arrival);
  assign turn_full = wait_full + WideW'(rd_q.burst);
  assign ridx_ext  = XIdxW'(ridx_q);

  // Job and start memories, registered read
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      job_mem[cnt_q[IdxW-1:0]] <= '{burst: burst_time_i, arrival: arrival_time_i,
                                    prio: job_priority_i};
    end
    if (commit_we) begin
      start_mem[pick_idx] <= pick_start;
    end
    rd_q    <= job_mem[rd_addr];
    st_rd_q <= start_mem[rd_addr];
  end

  // Sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      done_q      <= '0;
      tick_q      <= '0;
      served_q    <= '0;
      scan_q      <= '0;
      rv_q        <= 1'b0;
      ridx_q      <= '0;
      fnd_q       <= 1'b0;
      bpri_q      <= '0;
      bidx_q      <= '0;
      bburst_q    <= '0;
      eany_q      <= 1'b0;
      earr_q      <= '0;
      epri_q      <= '0;
      eidx_q      <= '0;
      eburst_q    <= '0;
      res_valid_q <= 1'b0;
      res_idx_q   <= '0;
      res_wait_q  <= '0;
      res_turn_q  <= '0;
      res_last_q  <= 1'b0;
    end else begin
      // Strobe a result word for each read returned while emitting
      res_valid_q <= (state_q == StEmit) && rv_q;
      unique case (state_q)
        StIdle: begin
          // Store the job word; start the first round on the last job
          if (load_we) begin
            cnt_q                     <= cnt_q + CntW'(1);
            served_q[cnt_q[IdxW-1:0]] <= 1'b0;
          end
          if (load_acc && last_job_i) begin
            state_q <= StScan;
            done_q  <= '0;
            scan_q  <= '0;
            rv_q    <= 1'b0;
            fnd_q   <= 1'b0;
            eany_q  <= 1'b0;
          end
        end
        StScan: begin
          // Advance the read address, fold each word into the trackers
          if (issue) begin
            scan_q <= scan_q + CntW'(1);
          end
          rv_q   <= issue;
          ridx_q <= rd_addr;
          if (take_best) begin
            fnd_q    <= 1'b1;
            bpri_q   <= rd_q.prio;
            bidx_q   <= ridx_q;
            bburst_q <= rd_q.burst;
          end
          if (take_early) begin
            eany_q   <= 1'b1;
            earr_q   <= rd_q.arrival;
            epri_q   <= rd_q.prio;
            eidx_q   <= ridx_q;
            eburst_q <= rd_q.burst;
          end
          if (rv_q && rd_is_last) begin
            state_q <= StCommit;
          end
        end
        StCommit: begin
          // Run the picked job to completion
          served_q[pick_idx] <= 1'b1;
          tick_q             <= pick_next;
          done_q             <= done_q + CntW'(1);
          scan_q             <= '0;
          rv_q               <= 1'b0;
          fnd_q              <= 1'b0;
          eany_q             <= 1'b0;
          if ((done_q + CntW'(1)) == cnt_q) begin
            state_q <= StEmit;
          end else begin
            state_q <= StScan;
          end
        end
        StEmit: begin
          // Stream one result word per job in index order
          if (issue) begin
            scan_q <= scan_q + CntW'(1);
          end
          rv_q   <= issue;
          ridx_q <= rd_addr;
          if (rv_q) begin
            res_idx_q   <= ridx_ext[JobIdxW-1:0];
            res_wait_q  <= wait_full[OutTimeW-1:0];
            res_turn_q  <= turn_full[OutTimeW-1:0];
            res_last_q  <= rd_is_last;
          end
          if (rv_q && rd_is_last) begin
            state_q  <= StIdle;
            cnt_q    <= '0;
            served_q <= '0;
            tick_q   <= '0;
            scan_q   <= '0;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign result_valid_o    = res_valid_q;
  assign job_index_o       = res_idx_q;
  assign waiting_time_o    = res_wait_q;
  assign turnaround_time_o = res_turn_q;
  assign last_result_o     = res_last_q;

  // Checks
  `NPS_ASSERT_NEXT(a_last_job_goes_busy, load_acc && last_job_i, busy_o,
                   "last job accepted but block did not go busy")
  `NPS_ASSERT_NEXT(a_last_result_ends_set, result_valid_o && last_result_o, !result_valid_o,
                   "result word follows the last result of a set")
  `NPS_ASSERT_NOW(a_count_bounded, 1'b1, cnt_q <= CntW'(MAX_PROCS),
                  "job count exceeds the store depth")
  `NPS_ASSERT_NOW(a_idle_no_read, state_q == StIdle, !rv_q,
                  "memory read pending while idle")

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for nonpreemptive_priority_scheduler_unit.
// Loads job sets through the start/busy port, predicts each job's waiting and
// turnaround times, and checks every result word. Depends on nps_pkg and the RTL.
module tb;
  import nps_pkg::*;

  localparam int unsigned MaxJobs      = 16;
  localparam int unsigned RandomJobs   = 125;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned SettleCycles = 20;

  typedef enum int {
    MixContended,
    MixSpread,
    MixBlend
  } job_mix_e;

  // One job word waiting to be offered, plus whether to drain the block first.
  typedef struct {
    job_t job;
    logic last;
    logic drain_first;
  } job_word_t;

  // Times the scheduler should report for one job.
  typedef struct {
    logic [JobIdxW-1:0]  index;
    logic [OutTimeW-1:0] waiting;
    logic [OutTimeW-1:0] turnaround;
    logic                last;
  } job_times_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [BurstW-1:0]   burst_time_i = '0;
  logic [ArrivalW-1:0] arrival_time_i = '0;
  logic [PrioW-1:0]    job_priority_i = '0;
  logic                last_job_i = 1'b0;
  logic                result_valid_o;
  logic [JobIdxW-1:0]  job_index_o;
  logic [OutTimeW-1:0] waiting_time_o;
  logic [OutTimeW-1:0] turnaround_time_o;
  logic                last_result_o;

  job_word_t  job_q[$];
  job_times_t times_q[$];
  job_times_t want;
  int         fail_count = 0;
  int         burst_left = 1;
  int         gap_left = 0;
  logic       word_taken;
  int         quiet_cycles = 0;

  // Predictor copy of the job store.
  job_t held_jobs[MaxJobs];
  logic held_served[MaxJobs];
  int   held_count = 0;

  nonpreemptive_priority_scheduler_unit #(
    .MAX_PROCS(MaxJobs)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .burst_time_i     (burst_time_i),
    .arrival_time_i   (arrival_time_i),
    .job_priority_i   (job_priority_i),
    .last_job_i       (last_job_i),
    .result_valid_o   (result_valid_o),
    .job_index_o      (job_index_o),
    .waiting_time_o   (waiting_time_o),
    .turnaround_time_o(turnaround_time_o),
    .last_result_o    (last_result_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Lowest priority value among arrived, unserved jobs; lowest index on ties.
  function automatic int pick_ready(logic [31:0] tick);
    int pick;
    pick = -1;
    for (int i = 0; i < held_count; i++) begin
      if (!held_served[i] && held_jobs[i].arrival <= tick &&
          (pick < 0 || held_jobs[i].prio < held_jobs[pick].prio)) begin
        pick = i;
      end
    end
    return pick;
  endfunction

  // Store an accepted job; on the final job run the schedule and queue the times.
  function automatic void load_job(job_t j, logic final_job);
    logic [31:0] tick;
    logic [31:0] earliest;
    logic [31:0] wait_ticks;
    logic [31:0] start_at[MaxJobs];
    int          pick;
    job_times_t  t;
    if (held_count < MaxJobs) begin
      held_jobs[held_count] = j;
      held_served[held_count] = 1'b0;
      held_count++;
    end
    if (!final_job) return;
    tick = '0;
    repeat (held_count) begin
      pick = pick_ready(tick);
      // CPU idle: jump ahead to the earliest pending arrival
      if (pick < 0) begin
        earliest = '1;
        for (int i = 0; i < held_count; i++) begin
          if (!held_served[i] && held_jobs[i].arrival < earliest) begin
            earliest = held_jobs[i].arrival;
          end
        end
        tick = earliest;
        pick = pick_ready(tick);
      end
      held_served[pick] = 1'b1;
      start_at[pick] = tick;
      tick = tick + held_jobs[pick].burst;
    end
    for (int k = 0; k < held_count; k++) begin
      wait_ticks   = start_at[k] - held_jobs[k].arrival;
      t.index      = k[JobIdxW-1:0];
      t.waiting    = wait_ticks[OutTimeW-1:0];
      t.turnaround = OutTimeW'(wait_ticks + held_jobs[k].burst);
      t.last       = (k == held_count - 1);
      times_q.push_back(t);
    end
    for (int i = 0; i < MaxJobs; i++) held_served[i] = 1'b0;
    held_count = 0;
  endfunction

  function automatic job_t random_job(job_mix_e mix);
    job_t j;
    case (mix)
      MixContended: begin
        j.burst   = BurstW'($urandom_range(0, 40));
        j.arrival = ArrivalW'($urandom_range(0, 60));
        j.prio    = PrioW'($urandom_range(0, 3));
      end
      MixSpread: begin
        j.burst   = BurstW'($urandom);
        j.arrival = ArrivalW'($urandom);
        j.prio    = PrioW'($urandom);
      end
      default: begin
        j.burst   = BurstW'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 200));
        j.arrival = ArrivalW'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 500));
        j.prio    = PrioW'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 7));
      end
    endcase
    return j;
  endfunction

  task automatic add_job(logic [BurstW-1:0] b, logic [ArrivalW-1:0] a,
                         logic [PrioW-1:0] p, logic last, logic drain);
    job_word_t w;
    w.job.burst   = b;
    w.job.arrival = a;
    w.job.prio    = p;
    w.last        = last;
    w.drain_first = drain;
    job_q.push_back(w);
  endtask

  // Offer queued words in bursts; hold the word while busy_o is high.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i        <= 1'b0;
      burst_time_i   <= '0;
      arrival_time_i <= '0;
      job_priority_i <= '0;
      last_job_i     <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else if (!(start_i && busy_o)) begin
      word_taken = start_i;
      if (word_taken) job_q.delete(0);
      if (gap_left != 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (job_q.size() == 0 ||
                   (job_q[0].drain_first && (word_taken || times_q.size() != 0))) begin
        start_i <= 1'b0;
      end else begin
        start_i        <= 1'b1;
        burst_time_i   <= job_q[0].job.burst;
        arrival_time_i <= job_q[0].job.arrival;
        job_priority_i <= job_q[0].job.prio;
        last_job_i     <= job_q[0].last;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = int'($urandom_range(1, 12));
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
        end
      end
    end
  end

  // Check result words against the oldest prediction, then predict on accepted jobs.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        if (times_q.size() == 0) begin
          $error("result word for job %0d with no job pending", job_index_o);
          fail_count++;
        end else begin
          want = times_q.pop_front();
          if (job_index_o !== want.index) begin
            $error("job_index: expected %0d, got %0d", want.index, job_index_o);
            fail_count++;
          end
          if (waiting_time_o !== want.waiting) begin
            $error("waiting_time: expected %0d, got %0d", want.waiting, waiting_time_o);
            fail_count++;
          end
          if (turnaround_time_o !== want.turnaround) begin
            $error("turnaround_time: expected %0d, got %0d", want.turnaround,
                   turnaround_time_o);
            fail_count++;
          end
          if (last_result_o !== want.last) begin
            $error("last_result: expected %0d, got %0d", want.last, last_result_o);
            fail_count++;
          end
        end
      end
      if (start_i && !busy_o) begin
        load_job('{burst: burst_time_i, arrival: arrival_time_i, prio: job_priority_i},
                 last_job_i);
      end
    end
  end

  // Abort when neither side moves a word for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    int       queued;
    int       kind;
    int       n_jobs;
    logic     drain;
    job_mix_e mix;
    job_t     j;

    // Single jobs at both extremes; the second leaves the CPU idle until 65535.
    add_job(16'd0, 16'd0, 8'd0, 1'b1, 1'b0);
    add_job(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0);
    // Equal priorities and arrivals: lowest index wins; drain the block first.
    add_job(16'd5, 16'd0, 8'd7, 1'b0, 1'b1);
    add_job(16'd3, 16'd0, 8'd7, 1'b0, 1'b0);
    add_job(16'd4, 16'd0, 8'd7, 1'b1, 1'b0);
    // Priority order with idle gaps between arrivals.
    add_job(16'd10, 16'd200, 8'd2, 1'b0, 1'b0);
    add_job(16'd20, 16'd0, 8'd9, 1'b0, 1'b0);
    add_job(16'd30, 16'd1000, 8'd0, 1'b1, 1'b0);
    // Full store of longest jobs in reverse priority; the extra final job is dropped.
    for (int k = 0; k < MaxJobs; k++) begin
      add_job(16'hFFFF, 16'd0, 8'(255 - k), 1'b0, 1'b0);
    end
    add_job(16'd1234, 16'd0, 8'd0, 1'b1, 1'b0);

    // Random sets: mostly small, some full, some overflowing.
    queued = 0;
    while (queued < RandomJobs) begin
      kind = int'($urandom_range(0, 11));
      if (kind == 0) n_jobs = int'(MaxJobs);
      else if (kind == 1) n_jobs = int'(MaxJobs + $urandom_range(1, 3));
      else n_jobs = int'($urandom_range(1, 6));
      mix   = job_mix_e'($urandom_range(0, 2));
      drain = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < n_jobs; k++) begin
        j = random_job(mix);
        add_job(j.burst, j.arrival, j.prio, k == n_jobs - 1, drain && k == 0);
      end
      queued += n_jobs;
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (job_q.size() != 0) @(negedge clk_i);
    while (times_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
